>>> hw/rtl/ipban_pkg.sv
// Shared types and constants for the expiring IPv4 ban table.
// Used by ipban_ctrl, ipban_dp and the top level expiring_ip_ban_table.
package ipban_pkg;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned OUT_DATA_W = 112;

  typedef enum logic [1:0] {
    OP_MATCH  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_EXPIRE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_INVALID   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ADD,
    CMD_REJECT,
    CMD_SCAN_START,
    CMD_SCAN_STEP,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] expiry;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    cmd_e    kind;
    status_e code;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op;
    logic addr_invalid;
    logic table_full;
    logic scan_done;
  } sts_t;

endpackage

>>> hw/rtl/ipban_ctrl.sv
// Controller state machine of the ban table: handshakes and command sequencing.
// Depends on ipban_pkg for the command and status structs.
module ipban_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  input  ipban_pkg::sts_t   sts_i,
  output ipban_pkg::cmd_t   cmd_o
);
  import ipban_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   s_tready_q, s_tready_d;
  logic   m_tvalid_q, m_tvalid_d;

  always_comb begin
    state_d    = state_q;
    s_tready_d = s_tready_q;
    m_tvalid_d = m_tvalid_q;
    cmd_o      = '{kind: CMD_NONE, code: ST_OK};
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i && s_tready_q) begin
          cmd_o.kind = CMD_LOAD;
          s_tready_d = 1'b0;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.op == OP_ADD) begin
          if (sts_i.addr_invalid) begin
            cmd_o = '{kind: CMD_REJECT, code: ST_INVALID};
          end else if (sts_i.table_full) begin
            cmd_o = '{kind: CMD_REJECT, code: ST_FULL};
          end else begin
            cmd_o.kind = CMD_ADD;
          end
          m_tvalid_d = 1'b1;
          state_d    = S_OUT;
        end else if (sts_i.op == OP_MATCH && sts_i.addr_invalid) begin
          cmd_o      = '{kind: CMD_REJECT, code: ST_INVALID};
          m_tvalid_d = 1'b1;
          state_d    = S_OUT;
        end else begin
          cmd_o.kind = CMD_SCAN_START;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          cmd_o.kind = CMD_FINISH;
          m_tvalid_d = 1'b1;
          state_d    = S_OUT;
        end else begin
          cmd_o.kind = CMD_SCAN_STEP;
        end
      end
      S_OUT: begin
        // hold the result until the transfer completes
        if (m_tready_i) begin
          m_tvalid_d = 1'b0;
          s_tready_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d    = S_IDLE;
        s_tready_d = 1'b1;
        m_tvalid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      s_tready_q <= 1'b1;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      s_tready_q <= s_tready_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  assign s_tready_o = s_tready_q;
  assign m_tvalid_o = m_tvalid_q;

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_tready_o && m_tvalid_o))
    else $error("input and output sides open at once");

  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> (!s_tready_o && state_q == S_DECIDE))
    else $error("input stayed open after a transfer");

  a_out_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tready_i) |=> (!m_tvalid_o && s_tready_o))
    else $error("result not retired after its transfer");

endmodule

>>> hw/rtl/ipban_dp.sv
// Datapath of the ban table: request registers, entry memory, scan counters
// and the result register. Depends on ipban_pkg; driven by ipban_ctrl commands.
module ipban_dp #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ipban_pkg::cmd_t               cmd_i,
  output ipban_pkg::sts_t               sts_o,
  input  logic [1:0]                    req_op_i,
  input  logic [ipban_pkg::IN_DATA_W-1:0]  req_data_i,
  output logic [1:0]                    res_status_o,
  output logic [ipban_pkg::OUT_DATA_W-1:0] res_data_o
);
  import ipban_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  // request registers
  op_e         op_q;
  logic [31:0] addr_q, mask_q, dur_q, now_q;

  // table state
  entry_t        mem_q [TABLE_ENTRIES];
  logic [CW-1:0] cnt_q;

  // scan state
  logic [CW-1:0] rd_q, wr_q;
  logic          rvld_q;
  logic          found_q;
  entry_t        rdata_q;

  // result register
  status_e     res_status_q;
  logic [3:0]  res_slot_q;
  entry_t      res_entry_q;
  logic [4:0]  res_expired_q;

  logic        is_step, is_add, issue;
  logic        expired, exact, masked, drop, hit;
  logic [31:0] new_expiry;
  entry_t      new_entry;

  assign is_step = (cmd_i.kind == CMD_SCAN_STEP);
  assign is_add  = (cmd_i.kind == CMD_ADD);
  assign issue   = is_step && (rd_q < cnt_q);

  assign expired = (rdata_q.expiry != 32'd0) && (rdata_q.expiry < now_q);
  assign exact   = (rdata_q.addr == addr_q) && (rdata_q.mask == mask_q);
  assign masked  = ((addr_q & rdata_q.mask) == (rdata_q.addr & rdata_q.mask));

  always_comb begin
    if (op_q == OP_REMOVE) begin
      drop = !found_q && exact;
      hit  = drop;
    end else begin
      drop = expired;
      hit  = (op_q == OP_MATCH) && !expired && !found_q && masked;
    end
  end

  // an all-ones duration, or a sum that wraps to zero, makes the entry permanent
  assign new_expiry = (dur_q == ALL_ONES) ? 32'd0 : now_q + dur_q;
  assign new_entry  = '{addr: addr_q, mask: mask_q, expiry: new_expiry};

  always_ff @(posedge clk_i) begin
    if (cmd_i.kind == CMD_LOAD) begin
      op_q   <= op_e'(req_op_i);
      addr_q <= req_data_i[31:0];
      mask_q <= req_data_i[63:32];
      dur_q  <= req_data_i[95:64];
      now_q  <= req_data_i[127:96];
    end
  end

  // single write port, single registered read port
  always_ff @(posedge clk_i) begin
    if (is_add) begin
      mem_q[cnt_q[IW-1:0]] <= new_entry;
    end else if (is_step && rvld_q && !drop) begin
      mem_q[wr_q[IW-1:0]] <= rdata_q;
    end
    if (issue) begin
      rdata_q <= mem_q[rd_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      rvld_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      case (cmd_i.kind)
        CMD_ADD: begin
          cnt_q <= cnt_q + CW'(1);
        end
        CMD_SCAN_START: begin
          rd_q    <= '0;
          wr_q    <= '0;
          rvld_q  <= 1'b0;
          found_q <= 1'b0;
        end
        CMD_SCAN_STEP: begin
          rvld_q <= issue;
          if (issue) begin
            rd_q <= rd_q + CW'(1);
          end
          if (rvld_q) begin
            if (hit) begin
              found_q <= 1'b1;
            end
            if (!drop) begin
              wr_q <= wr_q + CW'(1);
            end
          end
        end
        CMD_FINISH: begin
          cnt_q <= wr_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.kind)
      CMD_REJECT: begin
        res_status_q  <= cmd_i.code;
        res_slot_q    <= '0;
        res_entry_q   <= '0;
        res_expired_q <= '0;
      end
      CMD_ADD: begin
        res_status_q  <= ST_OK;
        res_slot_q    <= 4'(cnt_q);
        res_entry_q   <= new_entry;
        res_expired_q <= '0;
      end
      CMD_SCAN_START: begin
        res_slot_q  <= '0;
        res_entry_q <= '0;
      end
      CMD_SCAN_STEP: begin
        // capture the reported entry at its compacted slot
        if (rvld_q && hit) begin
          res_slot_q  <= 4'(wr_q);
          res_entry_q <= rdata_q;
        end
      end
      CMD_FINISH: begin
        if (op_q == OP_EXPIRE || found_q) begin
          res_status_q <= ST_OK;
        end else begin
          res_status_q <= ST_NOT_FOUND;
        end
        if (op_q == OP_REMOVE) begin
          res_expired_q <= '0;
        end else begin
          res_expired_q <= 5'(cnt_q - wr_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign sts_o.op           = op_q;
  assign sts_o.addr_invalid = (addr_q == ALL_ONES);
  assign sts_o.table_full   = (cnt_q == FULL_COUNT);
  assign sts_o.scan_done    = (rd_q == cnt_q) && !rvld_q;

  assign res_status_o = res_status_q;
  assign res_data_o   = {7'd0, res_expired_q, res_entry_q.expiry, res_entry_q.mask,
                         res_entry_q.addr, res_slot_q};

  a_wr_behind_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q <= rd_q)
    else $error("compaction write pointer passed the read pointer");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_COUNT)
    else $error("entry count above table size");

  a_add_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_add |-> (cnt_q < FULL_COUNT && addr_q != ALL_ONES))
    else $error("entry appended to a full table or with an invalid address");

endmodule

>>> hw/rtl/expiring_ip_ban_table.sv
// Top level of the expiring IPv4 ban table: stream ports, controller and datapath.
// Depends on ipban_pkg, ipban_ctrl and ipban_dp.
//
// Channel  Dir  Carries
// s_*      in   tuser: operation[1:0]; tdata: address, prefix_mask, duration, now
// m_*      out  tuser: status[1:0]; tdata: entry_slot, matched_address,
//               matched_mask, matched_expiry, expired_count
//
// One item at a time. Add and rejected requests raise the result from the decide
// state after the input transfer; match, remove and expire walk the stored
// entries through the entry memory, one per cycle, in the scan state first.
// The input reopens the cycle after the result transfer.
// Reset empties the table at once; memory contents need no clearing.
// The input stays closed from its transfer until the result has been taken.
module expiring_ip_ban_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  // address[31:0], prefix_mask[63:32], duration[95:64], now[127:96]
  input  logic [ipban_pkg::IN_DATA_W-1:0]   s_tdata_i,
  // operation[1:0]
  input  logic [1:0]                        s_tuser_i,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  // entry_slot[3:0], matched_address[35:4], matched_mask[67:36],
  // matched_expiry[99:68], expired_count[104:100], zero fill[111:105]
  output logic [ipban_pkg::OUT_DATA_W-1:0]  m_tdata_o,
  // status[1:0]
  output logic [1:0]                        m_tuser_o
);
  import ipban_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ipban_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ipban_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_op_i     (s_tuser_i),
    .req_data_i   (s_tdata_i),
    .res_status_o (m_tuser_o),
    .res_data_o   (m_tdata_o)
  );

endmodule
